>>> sv/pes_pkg.sv
package pes_pkg;

  localparam int EMOTION_ID_BITS = 8;
  localparam int TIME_BITS       = 48;
  localparam int DEADLINE_BITS   = TIME_BITS + 1;
  localparam int DUR_BITS        = 32;
  localparam int CFG_DATA_BITS   = 32;
  localparam int CFG_IDX_BITS    = 3;

  // item function codes
  localparam logic [1:0] FUNC_POST     = 2'd0;
  localparam logic [1:0] FUNC_OVERRIDE = 2'd1;
  localparam logic [1:0] FUNC_DECIDE   = 2'd2;
  localparam logic [1:0] FUNC_UNUSED   = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_DEFAULT_HOLD      = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_KIND_COOLDOWN     = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_BASELINE_INTERVAL = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_FAULT_EMOTION     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_DEFAULT_BASELINE  = 3'd4;

  typedef struct packed {
    logic [1:0]                 func;
    logic [TIME_BITS-1:0]       now_ms;
    logic [EMOTION_ID_BITS-1:0] emotion;
    logic                       emotion_given;
    logic [7:0]                 kind;
    logic [DUR_BITS-1:0]        duration_ms;
    logic                       fault;
  } in_item_t;

  typedef struct packed {
    logic [EMOTION_ID_BITS-1:0] shown_emotion;
    logic                       immediate;
  } out_item_t;

  typedef struct packed {
    logic [DUR_BITS-1:0]        default_hold_ms;
    logic [DUR_BITS-1:0]        kind_cooldown_ms;
    logic [DUR_BITS-1:0]        baseline_min_interval_ms;
    logic [EMOTION_ID_BITS-1:0] fault_emotion;
    logic [EMOTION_ID_BITS-1:0] default_baseline;
  } cfg_t;

  typedef struct packed {
    logic [EMOTION_ID_BITS-1:0] current_emotion;
    logic [EMOTION_ID_BITS-1:0] transient_emotion;
    logic [7:0]                 transient_kind_held;
    logic [DEADLINE_BITS-1:0]   transient_deadline;
    logic [DEADLINE_BITS-1:0]   cooldown_deadline;
    logic [EMOTION_ID_BITS-1:0] override_emotion;
    logic [DEADLINE_BITS-1:0]   override_deadline;
    logic [TIME_BITS-1:0]       last_baseline_switch;
  } state_t;

endpackage

>>> sv/pes_step.sv
module pes_step (
  input  pes_pkg::in_item_t  item_i,
  input  pes_pkg::state_t    state_i,
  input  pes_pkg::cfg_t      cfg_i,
  output pes_pkg::state_t    state_o,
  output logic               res_valid_o,
  output pes_pkg::out_item_t res_o
);

  logic [pes_pkg::DEADLINE_BITS-1:0]   now_ext;
  logic [pes_pkg::DUR_BITS-1:0]        hold;
  logic                                emo_ok;
  logic                                kind_blocked;
  logic                                transient_on;
  logic                                override_on;
  logic [pes_pkg::EMOTION_ID_BITS-1:0] want;
  logic                                cut;
  logic                                base;
  logic [pes_pkg::TIME_BITS-1:0]       since_switch;
  logic                                base_ok;

  assign now_ext      = {1'b0, item_i.now_ms};
  assign emo_ok       = item_i.emotion_given && (item_i.emotion != '0);
  assign hold         = (item_i.duration_ms != '0) ? item_i.duration_ms : cfg_i.default_hold_ms;
  assign kind_blocked = (now_ext < state_i.cooldown_deadline) && (item_i.kind != '0) &&
                        (state_i.transient_kind_held != '0) &&
                        (item_i.kind == state_i.transient_kind_held);
  assign transient_on = now_ext < state_i.transient_deadline;
  assign override_on  = (now_ext < state_i.override_deadline) &&
                        (state_i.override_emotion != '0);
  assign since_switch = item_i.now_ms - state_i.last_baseline_switch;
  assign base_ok      = (item_i.now_ms >= state_i.last_baseline_switch) &&
                        (since_switch >= {{(pes_pkg::TIME_BITS-pes_pkg::DUR_BITS){1'b0}},
                                          cfg_i.baseline_min_interval_ms});

  // priority: fault, transient, override, baseline
  always_comb begin
    base = 1'b0;
    if (item_i.fault) begin
      want = cfg_i.fault_emotion;
      cut  = 1'b1;
    end else if (transient_on) begin
      want = state_i.transient_emotion;
      cut  = 1'b1;
    end else if (override_on) begin
      want = state_i.override_emotion;
      cut  = 1'b0;
    end else begin
      want = item_i.emotion_given ? item_i.emotion : cfg_i.default_baseline;
      cut  = 1'b0;
      base = 1'b1;
    end
  end

  always_comb begin
    state_o     = state_i;
    res_valid_o = 1'b0;
    res_o.shown_emotion = want;
    res_o.immediate     = cut;
    unique case (item_i.func)
      pes_pkg::FUNC_POST: begin
        if (emo_ok && !kind_blocked) begin
          state_o.transient_emotion   = item_i.emotion;
          state_o.transient_kind_held = item_i.kind;
          state_o.transient_deadline  = now_ext +
            {{(pes_pkg::DEADLINE_BITS-pes_pkg::DUR_BITS){1'b0}}, hold};
          state_o.cooldown_deadline   = now_ext +
            {{(pes_pkg::DEADLINE_BITS-pes_pkg::DUR_BITS){1'b0}}, cfg_i.kind_cooldown_ms};
        end
      end
      pes_pkg::FUNC_OVERRIDE: begin
        if (emo_ok) begin
          state_o.override_emotion  = item_i.emotion;
          state_o.override_deadline = now_ext +
            {{(pes_pkg::DEADLINE_BITS-pes_pkg::DUR_BITS){1'b0}}, item_i.duration_ms};
        end else begin
          state_o.override_emotion  = '0;
          state_o.override_deadline = '0;
        end
      end
      pes_pkg::FUNC_DECIDE: begin
        if ((want != state_i.current_emotion) && (!base || base_ok)) begin
          res_valid_o             = 1'b1;
          state_o.current_emotion = want;
          if (base) begin
            state_o.last_baseline_switch = item_i.now_ms;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> sv/priority_expression_selector.sv
// path: a transaction is registered at the input, evaluated from that input register and
// its result (if any) is loaded into the output register
// throughput: one transaction per cycle; only a held output result stalls the input
// reset: asynchronous active low, clears valids and all selector state to zero and
// loads the register defaults (hold 3000, cooldown 2000, interval 1500, fault 1, base 2)
module priority_expression_selector (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration writes
  input  logic                               cfg_we_i,
  input  logic [pes_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [pes_pkg::CFG_DATA_BITS-1:0]  cfg_wdata_i,
  // input channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  pes_pkg::in_item_t                  in_item_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output pes_pkg::out_item_t                 out_item_o
);

  // configuration registers
  pes_pkg::cfg_t      cfg_q;

  // input register stage
  logic               in_valid_q;
  pes_pkg::in_item_t  in_item_q;

  // selector state
  pes_pkg::state_t    state_q;
  pes_pkg::state_t    state_d;

  // output register
  logic               out_valid_q;
  pes_pkg::out_item_t out_item_q;

  logic               res_valid;
  pes_pkg::out_item_t res;
  logic               advance;

  // the registered transaction moves on unless a finished result is still waiting
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;

  pes_step u_step (
    .item_i      (in_item_q),
    .state_i     (state_q),
    .cfg_i       (cfg_q),
    .state_o     (state_d),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // register file, decoded by index; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.default_hold_ms          <= 32'd3000;
      cfg_q.kind_cooldown_ms         <= 32'd2000;
      cfg_q.baseline_min_interval_ms <= 32'd1500;
      cfg_q.fault_emotion            <= 8'd1;
      cfg_q.default_baseline         <= 8'd2;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pes_pkg::REG_DEFAULT_HOLD:      cfg_q.default_hold_ms <= cfg_wdata_i;
        pes_pkg::REG_KIND_COOLDOWN:     cfg_q.kind_cooldown_ms <= cfg_wdata_i;
        pes_pkg::REG_BASELINE_INTERVAL: cfg_q.baseline_min_interval_ms <= cfg_wdata_i;
        pes_pkg::REG_FAULT_EMOTION:
          cfg_q.fault_emotion <= cfg_wdata_i[pes_pkg::EMOTION_ID_BITS-1:0];
        pes_pkg::REG_DEFAULT_BASELINE:
          cfg_q.default_baseline <= cfg_wdata_i[pes_pkg::EMOTION_ID_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // input stage: load whenever it is not stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      in_item_q <= in_item_i;
    end
  end

  // state commits in the same cycle the transaction leaves the input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_valid_q && advance) begin
      state_q <= state_d;
    end
  end

  // output register: filled by a decide that changes the shown emotion
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q && res_valid) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTHESIS
  // a pending result always names the emotion the selector believes is shown
  a_out_matches_current: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.shown_emotion == state_q.current_emotion))
    else $error("pending result differs from current emotion");

  // the input side only stalls behind a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output backpressure");

  // the shown emotion never changes without a result being loaded
  a_current_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.current_emotion != $past(state_q.current_emotion)) |-> out_valid_o)
    else $error("current emotion changed silently");
`endif

endmodule
